// ----- design/bdrp_pkg.sv -----
// bayer demosaic row pair: shared types, codes and the row rule lookup
// no dependencies; imported by every module of the block but bdrp_queue
`timescale 1ns / 1ps

package bdrp_pkg;

	// row rule: color order of the current row, even column first
	typedef enum logic [1:0] {
		RULE_BG = 2'd0,
		RULE_RG = 2'd1,
		RULE_GB = 2'd2,
		RULE_GR = 2'd3
	} rule_t;

	// mosaic order held in the pattern register
	typedef enum logic [1:0] {
		PAT_BGGR = 2'd0,
		PAT_GBRG = 2'd1,
		PAT_GRBG = 2'd2,
		PAT_RGGB = 2'd3
	} pattern_t;

	localparam pattern_t PATTERN_RESET = PAT_RGGB;

	// classification of one beat, carried with its samples through the queue
	typedef struct packed {
		rule_t rule;
		logic  last;
		logic  half;
	} item_ctrl_t;

	// row rule for a mosaic order and the row phase
	function automatic rule_t rule_lookup(input pattern_t pat, input logic phase);
		rule_t r;
		case (pat)
			PAT_BGGR: r = phase ? RULE_GR : RULE_BG;
			PAT_GBRG: r = phase ? RULE_RG : RULE_GB;
			PAT_GRBG: r = phase ? RULE_BG : RULE_GR;
			PAT_RGGB: r = phase ? RULE_GB : RULE_RG;
			default:  r = RULE_BG;
		endcase
		return r;
	endfunction

endpackage

// ----- design/bayer_demosaic_row_pair_core.sv -----
// bayer demosaic row pair: top level, front end, queue and back end
// depends on bdrp_pkg, bdrp_front, bdrp_queue, bdrp_back
//
// Usage
//   Input channel (in_valid / in_stall): one beat is one column pair of the
//   current Bayer row plus the same columns of its partner row, with the row
//   phase, last_pair and half_pair flags. Output channel (out_valid /
//   out_stall): one beat is a pair of pixels; second_valid marks the odd
//   pixel, row_end the last beat of a row. cfg_we / cfg_data load the mosaic
//   order (0 BGGR, 1 GBRG, 2 GRBG, 3 RGGB); write it only while idle.
//   Path: a result passes the queue and the back-end result register after
//   the beat that releases it is accepted. A mid-row pair releases the pair
//   before it; a last pair releases that one and itself, so its own result
//   follows behind the other.
//   Throughput: one beat per cycle unless the output stalls, set by the single
//   back-end result register; a last pair arriving behind a pending pair occupies the back
//   end twice, so with the default two-entry queue and beats arriving back
//   to back in_stall rises for one cycle after each such row.
//   Reset: mosaic order RGGB, queue empty, nothing pending, no output beat.
//   Stall: a stalled output beat holds; the back end waits, the queue fills
//   and then in_stall rises.
`timescale 1ns / 1ps

module bayer_demosaic_row_pair_core import bdrp_pkg::*; #(
	parameter int SAMPLE_BITS = 8,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   row_phase,
	input  logic [SAMPLE_BITS-1:0] cur_even,
	input  logic [SAMPLE_BITS-1:0] cur_odd,
	input  logic [SAMPLE_BITS-1:0] near_even,
	input  logic [SAMPLE_BITS-1:0] near_odd,
	input  logic                   last_pair,
	input  logic                   half_pair,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SAMPLE_BITS-1:0] blue_a,
	output logic [SAMPLE_BITS-1:0] green_a,
	output logic [SAMPLE_BITS-1:0] red_a,
	output logic [SAMPLE_BITS-1:0] blue_b,
	output logic [SAMPLE_BITS-1:0] green_b,
	output logic [SAMPLE_BITS-1:0] red_b,
	output logic                   second_valid,
	output logic                   row_end
);

	localparam int SB = SAMPLE_BITS;
	localparam int QW = $bits(item_ctrl_t) + 4 * SB;

	logic          q_full, q_push, q_pop, q_head_valid;
	item_ctrl_t    q_ctrl, head_ctrl;
	logic [QW-1:0] q_wdata, q_head;
	logic [SB-1:0] head_ce, head_co, head_ne, head_no;

	// front end: pattern register and classification
	bdrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.row_phase (row_phase),
		.last_pair (last_pair),
		.half_pair (half_pair),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_ctrl    (q_ctrl)
	);

	// queue entry: classification plus the four samples
	assign q_wdata = {q_ctrl, cur_even, cur_odd, near_even, near_odd};

	bdrp_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_wdata),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_data  (q_head)
	);

	assign {head_ctrl, head_ce, head_co, head_ne, head_no} = q_head;

	// back end: neighbor state, interpolation and result register
	bdrp_back #(
		.SAMPLE_BITS (SB)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_head_valid),
		.head_ctrl    (head_ctrl),
		.head_ce      (head_ce),
		.head_co      (head_co),
		.head_ne      (head_ne),
		.head_no      (head_no),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.blue_a       (blue_a),
		.green_a      (green_a),
		.red_a        (red_a),
		.blue_b       (blue_b),
		.green_b      (green_b),
		.red_b        (red_b),
		.second_valid (second_valid),
		.row_end      (row_end)
	);

endmodule

// ----- design/bdrp_front.sv -----
// bayer demosaic row pair: front end, pattern register and beat classification
// depends on bdrp_pkg; feeds bdrp_queue
`timescale 1ns / 1ps

module bdrp_front import bdrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       row_phase,
	input  logic       last_pair,
	input  logic       half_pair,
	input  logic       q_full,
	output logic       q_push,
	output item_ctrl_t q_ctrl
);

	pattern_t pattern_q;

	// pattern register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PATTERN_RESET;
		end else if (cfg_we) begin
			pattern_q <= pattern_t'(cfg_data);
		end
	end

	// accept while the queue has room
	assign in_stall = q_full;
	assign q_push   = in_valid & ~q_full;

	// classify: rule from pattern and phase, half pair only counts at row end
	always_comb begin
		q_ctrl.rule = rule_lookup(pattern_q, row_phase);
		q_ctrl.last = last_pair;
		q_ctrl.half = last_pair & half_pair;
	end

endmodule

// ----- design/bdrp_queue.sv -----
// bayer demosaic row pair: short fifo between front and back end
// no dependencies
`timescale 1ns / 1ps

module bdrp_queue #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- design/bdrp_back.sv -----
// bayer demosaic row pair: back end, neighbor state, interpolation, result register
// depends on bdrp_pkg; drains bdrp_queue
`timescale 1ns / 1ps

module bdrp_back import bdrp_pkg::*; #(
	parameter int SAMPLE_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  item_ctrl_t             head_ctrl,
	input  logic [SAMPLE_BITS-1:0] head_ce,
	input  logic [SAMPLE_BITS-1:0] head_co,
	input  logic [SAMPLE_BITS-1:0] head_ne,
	input  logic [SAMPLE_BITS-1:0] head_no,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SAMPLE_BITS-1:0] blue_a,
	output logic [SAMPLE_BITS-1:0] green_a,
	output logic [SAMPLE_BITS-1:0] red_a,
	output logic [SAMPLE_BITS-1:0] blue_b,
	output logic [SAMPLE_BITS-1:0] green_b,
	output logic [SAMPLE_BITS-1:0] red_b,
	output logic                   second_valid,
	output logic                   row_end
);

	localparam int SB = SAMPLE_BITS;

	function automatic logic [SB-1:0] avg2(input logic [SB-1:0] x, input logic [SB-1:0] y);
		logic [SB:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[SB:1];
	endfunction

	// neighbor state
	logic [SB-1:0] held_c_q, held_n_q;
	logic [SB-1:0] pend_ce_q, pend_co_q, pend_ne_q, pend_no_q;
	logic          pend_valid_q;
	logic          fin_due_q;

	// result register
	logic          out_valid_q;
	logic [SB-1:0] ba_q, ga_q, ra_q, bb_q, gb_q, rb_q;
	logic          second_q, end_q;

	logic          slot_free, emit_pend, emit_fin, produce, advance;
	logic [SB-1:0] left_c, left_n;
	logic [SB-1:0] lc, ln, ce, co, ne, no, rc, rn;
	logic          sec, fin;
	logic [SB-1:0] av_lco, av_lno, av_cer, av_ner;
	logic [SB-1:0] ba, ga, ra, bb, gb, rb;

	// sequencing: a pending pair leaves first, a row end pair leaves after it
	always_comb begin
		slot_free = ~out_valid_q | ~out_stall;
		emit_pend = head_valid & pend_valid_q & ~fin_due_q;
		emit_fin  = head_valid & head_ctrl.last & (~pend_valid_q | fin_due_q);
		produce   = emit_pend | emit_fin;
		advance   = head_valid & (slot_free | ~produce);
		pop       = advance & ~(emit_pend & head_ctrl.last);
	end

	// left neighbors of the head beat; at row start its own odd samples, zero for a half pair
	always_comb begin
		if (pend_valid_q) begin
			left_c = pend_co_q;
			left_n = pend_no_q;
		end else if (head_ctrl.half) begin
			left_c = '0;
			left_n = '0;
		end else begin
			left_c = head_co;
			left_n = head_no;
		end
	end

	// operand select for the result being formed
	always_comb begin
		if (emit_pend) begin
			lc  = held_c_q;
			ln  = held_n_q;
			ce  = pend_ce_q;
			co  = pend_co_q;
			ne  = pend_ne_q;
			no  = pend_no_q;
			rc  = head_ce;
			rn  = head_ne;
			sec = 1'b1;
			fin = 1'b0;
		end else begin
			lc  = left_c;
			ln  = left_n;
			ce  = head_ce;
			co  = head_ctrl.half ? left_c : head_co;
			ne  = head_ne;
			no  = head_ctrl.half ? left_n : head_no;
			rc  = head_ce;
			rn  = head_ne;
			sec = ~head_ctrl.half;
			fin = 1'b1;
		end
	end

	// floored averages and per-rule color placement
	always_comb begin
		av_lco = avg2(lc, co);
		av_lno = avg2(ln, no);
		av_cer = avg2(ce, rc);
		av_ner = avg2(ne, rn);
		case (head_ctrl.rule)
			RULE_BG: begin
				ba = ce;     ga = av_lco; ra = av_lno;
				bb = av_cer; gb = co;     rb = no;
			end
			RULE_RG: begin
				ba = av_lno; ga = av_lco; ra = ce;
				bb = no;     gb = co;     rb = av_cer;
			end
			RULE_GB: begin
				ba = av_lco; ga = ce;     ra = ne;
				bb = co;     gb = av_cer; rb = av_ner;
			end
			default: begin
				ba = ne;     ga = ce;     ra = av_lco;
				bb = av_ner; gb = av_cer; rb = co;
			end
		endcase
		if (!sec) begin
			bb = '0;
			gb = '0;
			rb = '0;
		end
	end

	// neighbor state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_c_q     <= '0;
			held_n_q     <= '0;
			pend_ce_q    <= '0;
			pend_co_q    <= '0;
			pend_ne_q    <= '0;
			pend_no_q    <= '0;
			pend_valid_q <= 1'b0;
			fin_due_q    <= 1'b0;
		end else if (advance) begin
			if (emit_pend && head_ctrl.last) begin
				fin_due_q <= 1'b1;
			end else begin
				fin_due_q <= 1'b0;
				held_c_q  <= left_c;
				held_n_q  <= left_n;
				if (head_ctrl.last) begin
					pend_valid_q <= 1'b0;
				end else begin
					pend_valid_q <= 1'b1;
					pend_ce_q    <= head_ce;
					pend_co_q    <= head_co;
					pend_ne_q    <= head_ne;
					pend_no_q    <= head_no;
				end
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= advance & produce;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && produce) begin
			ba_q     <= ba;
			ga_q     <= ga;
			ra_q     <= ra;
			bb_q     <= bb;
			gb_q     <= gb;
			rb_q     <= rb;
			second_q <= sec;
			end_q    <= fin;
		end
	end

	assign out_valid    = out_valid_q;
	assign blue_a       = ba_q;
	assign green_a      = ga_q;
	assign red_a        = ra_q;
	assign blue_b       = bb_q;
	assign green_b      = gb_q;
	assign red_b        = rb_q;
	assign second_valid = second_q;
	assign row_end      = end_q;

endmodule

// ----- bench/bayer_demosaic_row_pair_core_tb.sv -----
// testbench for bayer_demosaic_row_pair_core: directed table, then random rows per mosaic order
// depends on bdrp_pkg and bayer_demosaic_row_pair_core; checks every pixel beat against predicted or hand-typed pixels
`timescale 1ns / 1ps

module bayer_demosaic_row_pair_core_tb;
	import bdrp_pkg::*;

	typedef logic [7:0] sample_t;

	// one input beat: a column pair of the current row and its partner row
	typedef struct packed {
		logic    row_phase;
		sample_t cur_even;
		sample_t cur_odd;
		sample_t near_even;
		sample_t near_odd;
		logic    last_pair;
		logic    half_pair;
	} col_pair_t;

	// one output beat: the even and odd pixel
	typedef struct packed {
		sample_t blue_a;
		sample_t green_a;
		sample_t red_a;
		sample_t blue_b;
		sample_t green_b;
		sample_t red_b;
		logic    second_valid;
		logic    row_end;
	} pixel_pair_t;

	typedef struct packed {
		col_pair_t   beat;
		logic        hand;
		pixel_pair_t px;
	} dir_row_t;

	localparam pixel_pair_t NO_PX = '0;
	localparam int NDIR = 15;

	// hand-typed pixels only where the answer is obvious; other rows go through the predictor
	localparam dir_row_t DIRECTED [NDIR] = '{
		// half pair at row start: odd samples taken as zero
		'{'{1'b0, 8'hA5, 8'hFF, 8'h3C, 8'hFF, 1'b1, 1'b1}, 1'b1,
			'{8'h00, 8'h00, 8'hA5, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
		// single full pair, all samples at maximum
		'{'{1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0}, 1'b1,
			'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}},
		// single full pair, all samples zero
		'{'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0}, 1'b1,
			'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
		// half pair at row start on the second row
		'{'{1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1}, 1'b1,
			'{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
		// four pair row with a stray half flag
		'{'{1'b0, 8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0}, 1'b0, NO_PX},
		'{'{1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1}, 1'b0, NO_PX},
		'{'{1'b0, 8'h01, 8'h80, 8'h7F, 8'hFE, 1'b0, 1'b0}, 1'b0, NO_PX},
		'{'{1'b0, 8'hFE, 8'h7F, 8'h80, 8'h01, 1'b1, 1'b0}, 1'b0, NO_PX},
		// three pair row ending in a half pair
		'{'{1'b1, 8'h55, 8'hAA, 8'hAA, 8'h55, 1'b0, 1'b0}, 1'b0, NO_PX},
		'{'{1'b1, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b0, NO_PX},
		'{'{1'b1, 8'h80, 8'h12, 8'h34, 8'h99, 1'b1, 1'b1}, 1'b0, NO_PX},
		// phase changes under a pending pair
		'{'{1'b0, 8'h10, 8'h20, 8'h30, 8'h40, 1'b0, 1'b0}, 1'b0, NO_PX},
		'{'{1'b1, 8'hC3, 8'h3C, 8'hE7, 8'h7E, 1'b1, 1'b0}, 1'b0, NO_PX},
		// two pair row ending in a half pair
		'{'{1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0}, 1'b0, NO_PX},
		'{'{1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1}, 1'b0, NO_PX}
	};

	localparam pattern_t PHASE_PAT [8] = '{PAT_BGGR, PAT_GBRG, PAT_GRBG, PAT_RGGB,
		PAT_RGGB, PAT_BGGR, PAT_GRBG, PAT_GBRG};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_data = 2'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       row_phase = 1'b0;
	sample_t    cur_even = '0;
	sample_t    cur_odd = '0;
	sample_t    near_even = '0;
	sample_t    near_odd = '0;
	logic       last_pair = 1'b0;
	logic       half_pair = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	sample_t    blue_a, green_a, red_a, blue_b, green_b, red_b;
	logic       second_valid, row_end;

	// predictor state
	pattern_t    pattern_reg = PATTERN_RESET;
	sample_t     held_c = '0, held_n = '0;
	col_pair_t   pend = '0;
	logic        pend_valid = 1'b0;
	pixel_pair_t pixel_q [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int err_count = 0;
	int beat_count = 0;
	int result_count = 0;

	bayer_demosaic_row_pair_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.row_phase    (row_phase),
		.cur_even     (cur_even),
		.cur_odd      (cur_odd),
		.near_even    (near_even),
		.near_odd     (near_odd),
		.last_pair    (last_pair),
		.half_pair    (half_pair),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.blue_a       (blue_a),
		.green_a      (green_a),
		.red_a        (red_a),
		.blue_b       (blue_b),
		.green_b      (green_b),
		.red_b        (red_b),
		.second_valid (second_valid),
		.row_end      (row_end)
	);

	always #5 clk = ~clk;

	// receiver backpressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// floored mean of two samples
	function automatic sample_t mean2(sample_t x, sample_t y);
		logic [8:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[8:1];
	endfunction

	// color order of the current row from mosaic order and row phase
	function automatic rule_t row_rule(pattern_t pat, logic phase);
		case ({pat, phase})
			{PAT_BGGR, 1'b0}, {PAT_GRBG, 1'b1}: return RULE_BG;
			{PAT_BGGR, 1'b1}, {PAT_GRBG, 1'b0}: return RULE_GR;
			{PAT_GBRG, 1'b0}, {PAT_RGGB, 1'b1}: return RULE_GB;
			default:                             return RULE_RG;
		endcase
	endfunction

	// interpolate one pixel pair from its left odd, own and right even samples
	function automatic pixel_pair_t shade(rule_t rule, sample_t left_c, sample_t left_n,
		sample_t c_even, sample_t c_odd, sample_t n_even, sample_t n_odd,
		sample_t right_c, sample_t right_n, logic second, logic at_end);
		pixel_pair_t px;
		case (rule)
			RULE_BG: begin
				px.blue_a = c_even;
				px.green_a = mean2(left_c, c_odd);
				px.red_a = mean2(left_n, n_odd);
				px.blue_b = mean2(c_even, right_c);
				px.green_b = c_odd;
				px.red_b = n_odd;
			end
			RULE_RG: begin
				px.blue_a = mean2(left_n, n_odd);
				px.green_a = mean2(left_c, c_odd);
				px.red_a = c_even;
				px.blue_b = n_odd;
				px.green_b = c_odd;
				px.red_b = mean2(c_even, right_c);
			end
			RULE_GB: begin
				px.blue_a = mean2(left_c, c_odd);
				px.green_a = c_even;
				px.red_a = n_even;
				px.blue_b = c_odd;
				px.green_b = mean2(c_even, right_c);
				px.red_b = mean2(n_even, right_n);
			end
			default: begin
				px.blue_a = n_even;
				px.green_a = c_even;
				px.red_a = mean2(left_c, c_odd);
				px.blue_b = mean2(n_even, right_n);
				px.green_b = mean2(c_even, right_c);
				px.red_b = c_odd;
			end
		endcase
		if (!second) begin
			px.blue_b = '0;
			px.green_b = '0;
			px.red_b = '0;
		end
		px.second_valid = second;
		px.row_end = at_end;
		return px;
	endfunction

	// advance the predictor by one accepted beat; returns how many pixel beats it releases
	function automatic int demosaic_pair(col_pair_t p, output pixel_pair_t r0,
		output pixel_pair_t r1);
		rule_t       rule;
		logic        half;
		sample_t     left_c, left_n, c_odd, n_odd;
		pixel_pair_t px;
		int          n;
		rule = row_rule(pattern_reg, p.row_phase);
		half = p.last_pair && p.half_pair;
		c_odd = p.cur_odd;
		n_odd = p.near_odd;
		n = 0;
		r0 = NO_PX;
		r1 = NO_PX;
		// pending pair leaves first, its right neighbor is this beat
		if (pend_valid) begin
			r0 = shade(rule, held_c, held_n, pend.cur_even, pend.cur_odd, pend.near_even,
				pend.near_odd, p.cur_even, p.near_even, 1'b1, 1'b0);
			n = 1;
			left_c = pend.cur_odd;
			left_n = pend.near_odd;
		end else if (half) begin
			left_c = '0;
			left_n = '0;
		end else begin
			left_c = c_odd;
			left_n = n_odd;
		end
		// half pair replicates the left edge
		if (half) begin
			c_odd = left_c;
			n_odd = left_n;
		end
		if (p.last_pair) begin
			px = shade(rule, left_c, left_n, p.cur_even, c_odd, p.near_even, n_odd,
				p.cur_even, p.near_even, !half, 1'b1);
			if (n == 0)
				r0 = px;
			else
				r1 = px;
			n++;
			pend_valid = 1'b0;
		end else begin
			pend = p;
			pend.cur_odd = c_odd;
			pend.near_odd = n_odd;
			pend_valid = 1'b1;
		end
		held_c = left_c;
		held_n = left_n;
		return n;
	endfunction

	function automatic sample_t pick_sample();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return 8'h00;
		else if (r < 24)
			return 8'hFF;
		return sample_t'($urandom_range(255));
	endfunction

	// present one beat, hold it until accepted, then record what it releases
	task automatic drive_beat(col_pair_t p, logic hand, pixel_pair_t hand_px);
		pixel_pair_t r0, r1;
		int          n;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		row_phase <= p.row_phase;
		cur_even <= p.cur_even;
		cur_odd <= p.cur_odd;
		near_even <= p.near_even;
		near_odd <= p.near_odd;
		last_pair <= p.last_pair;
		half_pair <= p.half_pair;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n = demosaic_pair(p, r0, r1);
		if (hand) begin
			pixel_q.insert(pixel_q.size(), hand_px);
		end else begin
			if (n > 0)
				pixel_q.insert(pixel_q.size(), r0);
			if (n > 1)
				pixel_q.insert(pixel_q.size(), r1);
		end
		beat_count++;
	endtask

	// one row of random length, mostly well formed with some noise
	task automatic send_row();
		int        len;
		logic      phase;
		logic      half_end;
		col_pair_t p;
		len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
		phase = 1'($urandom_range(1));
		half_end = ($urandom_range(3) == 0);
		for (int i = 0; i < len; i++) begin
			p.row_phase = ($urandom_range(19) == 0) ? !phase : phase;
			p.cur_even = pick_sample();
			p.cur_odd = pick_sample();
			p.near_even = pick_sample();
			p.near_odd = pick_sample();
			p.last_pair = (i == len - 1);
			p.half_pair = p.last_pair ? half_end : ($urandom_range(9) == 0);
			drive_beat(p, 1'b0, NO_PX);
		end
	endtask

	// wait until every expected beat has arrived, then let the pipeline settle
	task automatic settle(int extra);
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pixel_q.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (pixel_q.size() != 0) begin
			$error("%0d expected pixel beats never arrived", pixel_q.size());
			err_count++;
			pixel_q.delete();
		end
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_pattern(pattern_t pat);
		cfg_we <= 1'b1;
		cfg_data <= pat;
		@(posedge clk);
		cfg_we <= 1'b0;
		pattern_reg = pat;
	endtask

	task automatic check_field(string name, sample_t want, sample_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// compare each output beat with the oldest expectation
	always @(posedge clk) begin : result_check
		pixel_pair_t want;
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (pixel_q.size() == 0) begin
				$error("pixel beat with nothing expected");
				err_count++;
			end else begin
				want = pixel_q.pop_front();
				check_field("blue_a", want.blue_a, blue_a);
				check_field("green_a", want.green_a, green_a);
				check_field("red_a", want.red_a, red_a);
				check_field("blue_b", want.blue_b, blue_b);
				check_field("green_b", want.green_b, green_b);
				check_field("red_b", want.red_b, red_b);
				check_field("second_valid", 8'(want.second_valid), 8'(second_valid));
				check_field("row_end", 8'(want.row_end), 8'(row_end));
			end
		end
	end

	// stimulus
	initial begin
		int start;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under the reset mosaic order
		for (int i = 0; i < NDIR; i++)
			drive_beat(DIRECTED[i].beat, DIRECTED[i].hand, DIRECTED[i].px);
		settle(4);

		// random rows, one mosaic order and one idling mode per phase
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 71; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 71; end
				default: begin send_idle_pct = 22; stall_pct = 22; end
			endcase
			write_pattern(PHASE_PAT[ph]);
			start = beat_count;
			while (beat_count - start < 240)
				send_row();
			settle(4);
		end

		stall_pct = 0;
		settle(8);
		$display("covered %0d column pair beats and %0d pixel beats", beat_count, result_count);
		$display("over all four mosaic orders, both row phases and mixed idling");
		if (err_count == 0)
			$display("bayer_demosaic_row_pair_core_tb: PASS");
		else
			$display("bayer_demosaic_row_pair_core_tb: FAIL");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("bayer_demosaic_row_pair_core_tb: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
design/bdrp_pkg.sv
design/bdrp_front.sv
design/bdrp_queue.sv
design/bdrp_back.sv
design/bayer_demosaic_row_pair_core.sv
bench/bayer_demosaic_row_pair_core_tb.sv
